@@ rtl/stick_to_servo_duty_with_failsafe_assert.svh @@
// Assertion macros for the stick-to-servo duty block.
// Used by the top-level RTL; expects clk_i and rst_ni in the including scope.
`ifndef STICK_TO_SERVO_DUTY_WITH_FAILSAFE_ASSERT_SVH
`define STICK_TO_SERVO_DUTY_WITH_FAILSAFE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define STSD_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle that implies a consequence in the next cycle.
`define STSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STSD_ASSERT_NOW(lbl, prop, msg)
`define STSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/stsd_pkg.sv @@
// Package for the stick-to-servo duty block: payload layouts, pipeline
// stage types, register indexes, reset values and the duty clamp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stsd_pkg;

  localparam int unsigned DutyW = 14;
  localparam logic [DutyW-1:0] DutyMax = 14'd10000;
  localparam logic [DutyW-1:0] CenterReset = 14'd750;

  localparam logic [12:0] SteerRangeReset = 13'd200;
  localparam logic [12:0] ThrottleRangeReset = 13'd500;
  localparam logic [13:0] NeutralReset = 14'd750;
  localparam logic [15:0] TimeoutReset = 16'd240;
  localparam logic [15:0] HoldDelayReset = 16'd100;

  localparam logic CmdReport = 1'b0;
  localparam logic CmdTick = 1'b1;
  localparam logic [7:0] AckReportId = 8'd1;

  // Division by 126: halve, then multiply by ceil(2^25 / 63) and shift by 25.
  // Exact for every halved product below 2^19.
  localparam int unsigned ProdW = 20;
  localparam int unsigned RecipShift = 25;
  localparam int unsigned MulW = 39;
  localparam logic [19:0] RecipMul = 20'd532611;
  localparam int unsigned SwingW = 14;

  typedef enum logic [2:0] {
    RegSteerRange    = 3'd0,
    RegThrottleRange = 3'd1,
    RegNeutral       = 3'd2,
    RegTimeout       = 3'd3,
    RegHoldDelay     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    DirZero = 2'd0,
    DirPos  = 2'd1,
    DirNeg  = 2'd2
  } dir_e;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]        pad;
    logic [7:0]        report_id;
    logic              btn_y;
    logic              btn_x;
    logic              btn_start;
    logic              btn_left;
    logic              btn_right;
    logic signed [7:0] stick_ry;
    logic signed [7:0] stick_x;
  } item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic             failsafe;
    logic             in_trim;
    logic             send_ack;
    logic             speed_update;
    logic [DutyW-1:0] speed_duty;
    logic [DutyW-1:0] steer_duty;
  } result_t;

  // Stage holding the raw swing products.
  typedef struct packed {
    logic             is_drive;
    result_t          res;
    dir_e             steer_dir;
    dir_e             thr_dir;
    logic             steer_neg1;
    logic             thr_neg1;
    logic [ProdW-1:0] steer_prod;
    logic [ProdW-1:0] thr_prod;
    logic [DutyW-1:0] center;
    logic [DutyW-1:0] neutral;
  } prod_stage_t;

  // Stage holding the divided swings.
  typedef struct packed {
    logic              is_drive;
    result_t           res;
    dir_e              steer_dir;
    dir_e              thr_dir;
    logic              steer_neg1;
    logic              thr_neg1;
    logic [SwingW-1:0] steer_q;
    logic [SwingW-1:0] thr_q;
    logic [DutyW-1:0]  center;
    logic [DutyW-1:0]  neutral;
  } quot_stage_t;

  function automatic logic [DutyW-1:0] clamp_duty(input logic signed [16:0] v);
    logic [DutyW-1:0] r;
    if (v < 17'sd0) begin
      r = '0;
    end else if (v > $signed({3'b000, DutyMax})) begin
      r = DutyMax;
    end else begin
      r = v[DutyW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/stick_to_servo_duty_with_failsafe.sv @@
// Gamepad report to steering/throttle servo duty, with steering trim and a
// report-timeout failsafe. Depends on stsd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "stick_to_servo_duty_with_failsafe_assert.svh"

// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid / tready        tdata: gamepad report fields, tuser: cmd
// m_axis    out        tvalid / tready        tdata: duties and status flags
// apb       in         psel/penable/pready    five configuration registers, 4-byte stride
//
// One transaction is accepted per cycle when the output side keeps up. An accepted
// item runs through four register stages (input, swing product, reciprocal
// multiply, result); the multiply by the reciprocal of 126 sets the stage split.
// Items without a result leave the pipeline after the first stage. Reset clears
// the valid flags and block state and loads the register reset values. A stall
// on m_axis holds the stages; bubbles are filled.

module stick_to_servo_duty_with_failsafe #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] stick_x, [15:8] stick_ry, [16] btn_right, [17] btn_left,
  // [18] btn_start, [19] btn_x, [20] btn_y, [28:21] report_id, [31:29] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] cmd
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [13:0] steer_duty, [27:14] speed_duty, [28] speed_update, [29] send_ack,
  // [30] in_trim, [31] failsafe
  output logic [31:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase.
  // ---------------------------------------------------------------------------
  logic [12:0] steer_range_q;
  logic [12:0] throttle_range_q;
  logic [13:0] neutral_q;
  logic [15:0] timeout_q;
  logic [15:0] hold_delay_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_range_q    <= stsd_pkg::SteerRangeReset;
      throttle_range_q <= stsd_pkg::ThrottleRangeReset;
      neutral_q        <= stsd_pkg::NeutralReset;
      timeout_q        <= stsd_pkg::TimeoutReset;
      hold_delay_q     <= stsd_pkg::HoldDelayReset;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        stsd_pkg::RegSteerRange:    steer_range_q    <= pwdata[12:0];
        stsd_pkg::RegThrottleRange: throttle_range_q <= pwdata[12:0];
        stsd_pkg::RegNeutral:       neutral_q        <= pwdata[13:0];
        stsd_pkg::RegTimeout:       timeout_q        <= pwdata[15:0];
        stsd_pkg::RegHoldDelay:     hold_delay_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      stsd_pkg::RegSteerRange:    prdata = {19'd0, steer_range_q};
      stsd_pkg::RegThrottleRange: prdata = {19'd0, throttle_range_q};
      stsd_pkg::RegNeutral:       prdata = {18'd0, neutral_q};
      stsd_pkg::RegTimeout:       prdata = {16'd0, timeout_q};
      stsd_pkg::RegHoldDelay:     prdata = {16'd0, hold_delay_q};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or moving on, so
  // a stall at the output only backs up as far as the first empty stage.
  // ---------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, vo_q;
  logic out_ready, ld2_ok, ld1_ok, ld0_ok;
  logic mv0, mv1, mv2;

  assign out_ready = !vo_q || m_axis_tready;
  assign mv2       = v2_q && out_ready;
  assign ld2_ok    = !v2_q || out_ready;
  assign mv1       = v1_q && ld2_ok;
  assign ld1_ok    = !v1_q || ld2_ok;
  assign mv0       = v0_q && ld1_ok;
  assign ld0_ok    = !v0_q || ld1_ok;

  assign s_axis_tready = ld0_ok;
  assign m_axis_tvalid = vo_q;

  // Stage 0: input register.
  stsd_pkg::item_t d0_q;
  logic            cmd0_q;

  always_ff @(posedge clk_i) begin
    if (ld0_ok && s_axis_tvalid) begin
      d0_q   <= stsd_pkg::item_t'(s_axis_tdata);
      cmd0_q <= s_axis_tuser[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Block state. It is updated as an item leaves stage 0, so every item sees
  // the state left by the one before it, in order.
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] ms_q, ms_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [TIME_BITS-1:0] rstart_q, rstart_d;
  logic [TIME_BITS-1:0] lstart_q, lstart_d;
  logic [13:0]          center_q, center_d;
  logic                 trim_q, trim_d;
  logic                 rheld_q, rheld_d;
  logic                 lheld_q, lheld_d;

  logic [TIME_BITS-1:0] ms_inc;
  logic [TIME_BITS-1:0] tick_elapsed;
  logic [TIME_BITS-1:0] r_elapsed;
  logic [TIME_BITS-1:0] l_elapsed;
  logic                 step_up, step_dn;
  logic [13:0]          center_mid, center_trim;
  logic                 id_ack;
  logic [6:0]           mag_x, mag_ry;
  logic [12:0]          steer_rm1, thr_rm1;
  logic                 has_res;
  stsd_pkg::prod_stage_t s1_d, s1_q;

  assign ms_inc       = ms_q + TIME_BITS'(1);
  assign tick_elapsed = ms_inc - last_q;
  assign r_elapsed    = ms_q - rstart_q;
  assign l_elapsed    = ms_q - lstart_q;
  assign id_ack       = (d0_q.report_id == stsd_pkg::AckReportId);

  // A button steps the center only once it was already held on the last
  // report and the hold has lasted longer than the delay. Right is applied
  // before left, each saturating on its own.
  assign step_up = d0_q.btn_right && rheld_q && (r_elapsed > TIME_BITS'(hold_delay_q));
  assign step_dn = d0_q.btn_left && lheld_q && (l_elapsed > TIME_BITS'(hold_delay_q));
  assign center_mid  = (step_up && (center_q < stsd_pkg::DutyMax)) ? center_q + 14'd1
                                                                    : center_q;
  assign center_trim = (step_dn && (center_mid != 14'd0)) ? center_mid - 14'd1 : center_mid;

  // Magnitude minus one of a nonzero stick value: x-1 when positive, ~x when
  // negative, which gives 127 for the most negative code.
  assign mag_x  = d0_q.stick_x[7] ? ~d0_q.stick_x[6:0] : d0_q.stick_x[6:0] - 7'd1;
  assign mag_ry = d0_q.stick_ry[7] ? ~d0_q.stick_ry[6:0] : d0_q.stick_ry[6:0] - 7'd1;
  assign steer_rm1 = steer_range_q - 13'd1;
  assign thr_rm1   = throttle_range_q - 13'd1;

  always_comb begin
    ms_d     = ms_q;
    last_d   = last_q;
    rstart_d = rstart_q;
    lstart_d = lstart_q;
    center_d = center_q;
    trim_d   = trim_q;
    rheld_d  = rheld_q;
    lheld_d  = lheld_q;
    has_res  = 1'b0;
    s1_d     = '0;

    // Drive-mode swing products. A range of zero makes the factor minus one,
    // so the truncated quotient is minus one only for the two largest
    // magnitudes and zero otherwise.
    s1_d.steer_dir  = (d0_q.stick_x == 8'sd0) ? stsd_pkg::DirZero :
                      (d0_q.stick_x[7] ? stsd_pkg::DirNeg : stsd_pkg::DirPos);
    s1_d.thr_dir    = (d0_q.stick_ry == 8'sd0) ? stsd_pkg::DirZero :
                      (d0_q.stick_ry[7] ? stsd_pkg::DirNeg : stsd_pkg::DirPos);
    s1_d.steer_neg1 = (steer_range_q == 13'd0) && (mag_x[6:1] == 6'h3f);
    s1_d.thr_neg1   = (throttle_range_q == 13'd0) && (mag_ry[6:1] == 6'h3f);
    s1_d.steer_prod = (steer_range_q == 13'd0) ? '0
                    : {13'd0, mag_x} * {7'd0, steer_rm1};
    s1_d.thr_prod   = (throttle_range_q == 13'd0) ? '0
                    : {13'd0, mag_ry} * {7'd0, thr_rm1};
    s1_d.center     = center_q;
    s1_d.neutral    = neutral_q;

    if (mv0) begin
      if (cmd0_q == stsd_pkg::CmdTick) begin
        ms_d = ms_inc;
        if (!trim_q && (tick_elapsed > TIME_BITS'(timeout_q))) begin
          has_res                   = 1'b1;
          s1_d.res.steer_duty       = stsd_pkg::clamp_duty($signed({3'b000, neutral_q}));
          s1_d.res.speed_duty       = stsd_pkg::clamp_duty($signed({3'b000, neutral_q}));
          s1_d.res.speed_update     = 1'b1;
          s1_d.res.failsafe         = 1'b1;
        end
      end else begin
        last_d  = ms_q;
        has_res = 1'b1;
        if (trim_q) begin
          rheld_d  = d0_q.btn_right;
          lheld_d  = d0_q.btn_left;
          if (d0_q.btn_right && !rheld_q) begin
            rstart_d = ms_q;
          end
          if (d0_q.btn_left && !lheld_q) begin
            lstart_d = ms_q;
          end
          center_d            = center_trim;
          trim_d              = !d0_q.btn_start;
          s1_d.res.steer_duty = center_trim;
          s1_d.res.send_ack   = id_ack;
          s1_d.res.in_trim    = !d0_q.btn_start;
        end else if (d0_q.btn_x && d0_q.btn_y) begin
          trim_d              = 1'b1;
          rheld_d             = 1'b0;
          lheld_d             = 1'b0;
          s1_d.res.steer_duty = center_q;
          s1_d.res.in_trim    = 1'b1;
        end else begin
          s1_d.is_drive         = 1'b1;
          s1_d.res.speed_update = 1'b1;
          s1_d.res.send_ack     = id_ack;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q     <= '0;
      last_q   <= '0;
      rstart_q <= '0;
      lstart_q <= '0;
      center_q <= stsd_pkg::CenterReset;
      trim_q   <= 1'b0;
      rheld_q  <= 1'b0;
      lheld_q  <= 1'b0;
    end else begin
      ms_q     <= ms_d;
      last_q   <= last_d;
      rstart_q <= rstart_d;
      lstart_q <= lstart_d;
      center_q <= center_d;
      trim_q   <= trim_d;
      rheld_q  <= rheld_d;
      lheld_q  <= lheld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: divide both products by 126 through the reciprocal.
  // ---------------------------------------------------------------------------
  logic [stsd_pkg::MulW-1:0] steer_mul, thr_mul;
  stsd_pkg::quot_stage_t     s2_d, s2_q;

  assign steer_mul = stsd_pkg::MulW'(s1_q.steer_prod[stsd_pkg::ProdW-1:1])
                   * stsd_pkg::MulW'(stsd_pkg::RecipMul);
  assign thr_mul   = stsd_pkg::MulW'(s1_q.thr_prod[stsd_pkg::ProdW-1:1])
                   * stsd_pkg::MulW'(stsd_pkg::RecipMul);

  always_comb begin
    s2_d.is_drive   = s1_q.is_drive;
    s2_d.res        = s1_q.res;
    s2_d.steer_dir  = s1_q.steer_dir;
    s2_d.thr_dir    = s1_q.thr_dir;
    s2_d.steer_neg1 = s1_q.steer_neg1;
    s2_d.thr_neg1   = s1_q.thr_neg1;
    s2_d.steer_q    = steer_mul[stsd_pkg::RecipShift +: stsd_pkg::SwingW];
    s2_d.thr_q      = thr_mul[stsd_pkg::RecipShift +: stsd_pkg::SwingW];
    s2_d.center     = s1_q.center;
    s2_d.neutral    = s1_q.neutral;
  end

  // ---------------------------------------------------------------------------
  // Stage 2 -> output: apply the swings around center and neutral, saturate.
  // Forward throttle lowers the duty, reverse raises it.
  // ---------------------------------------------------------------------------
  logic signed [16:0] steer_sw, thr_sw, center_s, neutral_s, steer_val, thr_val;
  stsd_pkg::result_t  out_d, out_q;

  assign steer_sw  = s2_q.steer_neg1 ? -17'sd1 : $signed({3'b000, s2_q.steer_q});
  assign thr_sw    = s2_q.thr_neg1 ? -17'sd1 : $signed({3'b000, s2_q.thr_q});
  assign center_s  = $signed({3'b000, s2_q.center});
  assign neutral_s = $signed({3'b000, s2_q.neutral});

  always_comb begin
    case (s2_q.steer_dir)
      stsd_pkg::DirPos: steer_val = center_s + 17'sd1 + steer_sw;
      stsd_pkg::DirNeg: steer_val = center_s - 17'sd1 - steer_sw;
      default:          steer_val = center_s;
    endcase
    case (s2_q.thr_dir)
      stsd_pkg::DirPos: thr_val = neutral_s - 17'sd1 - thr_sw;
      stsd_pkg::DirNeg: thr_val = neutral_s + 17'sd1 + thr_sw;
      default:          thr_val = neutral_s;
    endcase
    out_d = s2_q.res;
    if (s2_q.is_drive) begin
      out_d.steer_duty = stsd_pkg::clamp_duty(steer_val);
      out_d.speed_duty = stsd_pkg::clamp_duty(thr_val);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1_ok && mv0) begin
      s1_q <= s1_d;
    end
    if (ld2_ok && mv1) begin
      s2_q <= s2_d;
    end
    if (out_ready && mv2) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld0_ok) begin
        v0_q <= s_axis_tvalid;
      end
      if (ld1_ok) begin
        v1_q <= mv0 && has_res;
      end
      if (ld2_ok) begin
        v2_q <= mv1;
      end
      if (out_ready) begin
        vo_q <= mv2;
      end
    end
  end

  assign m_axis_tdata = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `STSD_ASSERT_NOW(a_center_range, center_q <= stsd_pkg::DutyMax, "steering center out of range")
  `STSD_ASSERT_NEXT(a_center_trim_only, !(mv0 && (cmd0_q == stsd_pkg::CmdReport) && trim_q), $stable(center_q), "center moved outside a trim report")
  `STSD_ASSERT_NOW(a_out_duty_range, vo_q |-> ((out_q.steer_duty <= stsd_pkg::DutyMax) && (out_q.speed_duty <= stsd_pkg::DutyMax)), "result duty above full scale")
  `STSD_ASSERT_NOW(a_failsafe_shape, (vo_q && out_q.failsafe) |-> (out_q.speed_update && !out_q.in_trim && !out_q.send_ack), "malformed failsafe result")
  `STSD_ASSERT_NOW(a_trim_no_speed, (vo_q && out_q.in_trim) |-> (!out_q.speed_update && (out_q.speed_duty == '0)), "trim result drives throttle")

endmodule

`default_nettype wire
